// File: hw/rtl/vn2d_pkg.sv
// Shared types and hash constants for the 2D value noise pipeline.
`default_nettype none

package vn2d_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NOISE_W = 21;
  localparam int unsigned HASH_W  = 32;

  localparam logic [HASH_W-1:0] HASH_MUL = 32'd15731;
  localparam logic [HASH_W-1:0] HASH_ADD = 32'd789221;
  localparam logic [HASH_W-1:0] HASH_OFS = 32'd1376312589;
  localparam int unsigned       HASH_SHL = 13;

  typedef logic signed [HASH_W-1:0] lat_t;

  localparam lat_t LAT_ONE = 32'sh4000_0000;

  typedef struct packed {
    logic sq;
    logic mix;
    logic fin;
  } vn2d_hash_en_t;

endpackage

`default_nettype wire

// File: hw/rtl/vn2d_hash.sv
// Three-stage lattice hash: mixed corner index in, Q2.30 lattice value out.
`default_nettype none

module vn2d_hash (
  input  logic                          clk_i,
  input  vn2d_pkg::vn2d_hash_en_t       en_i,
  input  logic [vn2d_pkg::HASH_W-1:0]   n_i,
  output vn2d_pkg::lat_t                lat_o
);
  import vn2d_pkg::*;

  logic [HASH_W-1:0] n_a_q;
  logic [HASH_W-1:0] sq_q;
  logic [HASH_W-1:0] n_b_q;
  logic [HASH_W-1:0] m_q;
  logic [HASH_W-1:0] h;
  lat_t              lat_q;

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      n_a_q <= n_i;
      sq_q  <= n_i * n_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mix) begin
      n_b_q <= n_a_q;
      m_q   <= sq_q * HASH_MUL + HASH_ADD;
    end
  end

  assign h = n_b_q * m_q + HASH_OFS;

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      lat_q <= LAT_ONE - $signed({1'b0, h[HASH_W-2:0]});
    end
  end

  assign lat_o = lat_q;

endmodule

`default_nettype wire

// File: hw/rtl/value_noise_2d_top.sv
// Throughput: one transaction per cycle while the output is not stalled; every stage holds its own valid bit,
// so a stalled output only backs up stages that are full.
// Reset clears all stage valid bits and sets the blend mode to smoothstep.
// No memories; the block is ready to accept input as soon as reset is released.
`default_nettype none

module value_noise_2d_top #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ROW_STRIDE = 257
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_interp_mode_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [vn2d_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [vn2d_pkg::COORD_W-1:0]  y_coord_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [vn2d_pkg::NOISE_W-1:0]  noise_value_o
);
  import vn2d_pkg::*;

  localparam int unsigned NS  = 13;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned WW  = F + 2;
  localparam int unsigned TW  = 2 * F;
  localparam int unsigned PW  = 2 * F + 2;
  localparam int unsigned DW  = HASH_W + 1;
  localparam int unsigned XPW = WW + DW;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned YW  = RW + 1;
  localparam int unsigned YPW = WW + YW;
  localparam int unsigned FW  = YW + 1;
  localparam int unsigned SH  = 30 - F;

  localparam logic INTERP_SMOOTH = 1'b1;

  localparam logic [HASH_W-1:0]    STRIDE    = HASH_W'(ROW_STRIDE);
  localparam logic [TW-1:0]        HALF_TT   = TW'(1) << (F - 1);
  localparam logic [PW-1:0]        HALF_P    = PW'(1) << (F - 1);
  localparam logic [WW-1:0]        THREE_ONE = WW'(3) << F;
  localparam logic signed [XPW-1:0] HALF_XP  = XPW'(1) << (F - 1);
  localparam logic signed [YPW-1:0] HALF_YP  = YPW'(1) << (F - 1);
  localparam logic signed [FW-1:0]  HALF_F   = FW'(1) << (SH - 1);
  localparam logic signed [FW-1:0]  OUT_HI   = FW'((1 << (NOISE_W - 1)) - 1);
  localparam logic signed [FW-1:0]  OUT_LO   = ~OUT_HI;

  // handshake and stage valids
  logic          mode_q;
  logic [NS:1]   v_q;
  logic [NS:1]   vin;
  logic [NS+1:1] go;
  logic [NS:1]   ld;

  assign cfg_ready_o = 1'b1;
  assign vin = {v_q[NS-1:1], in_valid_i};

  always_comb begin
    go[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      go[k] = !v_q[k] || go[k+1];
    end
    ld = go[NS:1] & vin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      mode_q <= INTERP_SMOOTH;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (go[k]) begin
          v_q[k] <= vin[k];
        end
      end
      if (cfg_valid_i) begin
        mode_q <= cfg_interp_mode_i;
      end
    end
  end

  assign in_ready_o  = go[1];
  assign out_valid_o = v_q[NS];

  // stage 1: split into truncated integer and signed fraction
  logic signed [COORD_W-1:0] x_fl, y_fl;
  logic [F-1:0]              x_lo, y_lo;
  logic                      x_neg, y_neg;
  logic [HASH_W-1:0]         xi1_q, yi1_q;
  logic [F-1:0]              xlo1_q, ylo1_q;
  logic                      xneg1_q, yneg1_q;

  assign x_fl  = x_coord_i >>> F;
  assign y_fl  = y_coord_i >>> F;
  assign x_lo  = x_coord_i[F-1:0];
  assign y_lo  = y_coord_i[F-1:0];
  assign x_neg = x_coord_i[COORD_W-1] && (x_lo != '0);
  assign y_neg = y_coord_i[COORD_W-1] && (y_lo != '0);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      xi1_q   <= x_fl + {{(HASH_W-1){1'b0}}, x_neg};
      yi1_q   <= y_fl + {{(HASH_W-1){1'b0}}, y_neg};
      xlo1_q  <= x_lo;
      ylo1_q  <= y_lo;
      xneg1_q <= x_neg;
      yneg1_q <= y_neg;
    end
  end

  // stage 2: row offset, clamped fraction squared
  logic [F-1:0]          tx1, ty1;
  logic [HASH_W-1:0]     xi2_q, row2_q;
  logic [F-1:0]          tx2_q, ty2_q;
  logic [TW-1:0]         ttx2_q, tty2_q;
  logic signed [WW-1:0]  xf2_q, yf2_q;

  assign tx1 = xneg1_q ? '0 : xlo1_q;
  assign ty1 = yneg1_q ? '0 : ylo1_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      xi2_q  <= xi1_q;
      row2_q <= yi1_q * STRIDE;
      tx2_q  <= tx1;
      ty2_q  <= ty1;
      ttx2_q <= TW'(tx1) * TW'(tx1);
      tty2_q <= TW'(ty1) * TW'(ty1);
      xf2_q  <= $signed({xneg1_q, xneg1_q, xlo1_q});
      yf2_q  <= $signed({yneg1_q, yneg1_q, ylo1_q});
    end
  end

  // stage 3: corner indices with xor-shift, ease product
  logic [HASH_W-1:0]    base2;
  logic [HASH_W-1:0]    n_d [4];
  logic [HASH_W-1:0]    nmix3_q [4];
  logic [TW-1:0]        ttrx, ttry;
  logic [WW-1:0]        kx, ky;
  logic [PW-1:0]        prx3_q, pry3_q;
  logic signed [WW-1:0] xf3_q, yf3_q;

  assign base2  = xi2_q + row2_q;
  assign n_d[0] = base2;
  assign n_d[1] = base2 + HASH_W'(1);
  assign n_d[2] = base2 + STRIDE;
  assign n_d[3] = base2 + STRIDE + HASH_W'(1);

  assign ttrx = ttx2_q + HALF_TT;
  assign ttry = tty2_q + HALF_TT;
  assign kx   = THREE_ONE - {1'b0, tx2_q, 1'b0};
  assign ky   = THREE_ONE - {1'b0, ty2_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      for (int c = 0; c < 4; c++) begin
        nmix3_q[c] <= (n_d[c] << HASH_SHL) ^ n_d[c];
      end
      prx3_q <= PW'(ttrx[TW-1:F]) * PW'(kx);
      pry3_q <= PW'(ttry[TW-1:F]) * PW'(ky);
      xf3_q  <= xf2_q;
      yf3_q  <= yf2_q;
    end
  end

  // stages 4..6: lattice hash per corner, weights ride alongside
  vn2d_hash_en_t hash_en;
  lat_t          lat [4];

  assign hash_en.sq  = ld[4];
  assign hash_en.mix = ld[5];
  assign hash_en.fin = ld[6];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    vn2d_hash u_hash (
      .clk_i (clk_i),
      .en_i  (hash_en),
      .n_i   (nmix3_q[c]),
      .lat_o (lat[c])
    );
  end

  logic [PW-1:0]        prrx, prry;
  logic signed [WW-1:0] wx4_q, wy4_q, wx5_q, wy5_q, wx6_q, wy6_q;

  assign prrx = prx3_q + HALF_P;
  assign prry = pry3_q + HALF_P;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      wx4_q <= (mode_q == INTERP_SMOOTH) ? $signed(prrx[PW-1:F]) : xf3_q;
      wy4_q <= (mode_q == INTERP_SMOOTH) ? $signed(prry[PW-1:F]) : yf3_q;
    end
    if (ld[5]) begin
      wx5_q <= wx4_q;
      wy5_q <= wy4_q;
    end
    if (ld[6]) begin
      wx6_q <= wx5_q;
      wy6_q <= wy5_q;
    end
  end

  // stage 7: x differences
  logic signed [DW-1:0] dx0_7_q, dx1_7_q;
  lat_t                 l00_7_q, l10_7_q;
  logic signed [WW-1:0] wx7_q, wy7_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      dx0_7_q <= DW'(lat[1]) - DW'(lat[0]);
      dx1_7_q <= DW'(lat[3]) - DW'(lat[2]);
      l00_7_q <= lat[0];
      l10_7_q <= lat[2];
      wx7_q   <= wx6_q;
      wy7_q   <= wy6_q;
    end
  end

  // stage 8: x weight products
  logic signed [XPW-1:0] p0_8_q, p1_8_q;
  lat_t                  l00_8_q, l10_8_q;
  logic signed [WW-1:0]  wy8_q;

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      p0_8_q  <= XPW'(wx7_q) * XPW'(dx0_7_q);
      p1_8_q  <= XPW'(wx7_q) * XPW'(dx1_7_q);
      l00_8_q <= l00_7_q;
      l10_8_q <= l10_7_q;
      wy8_q   <= wy7_q;
    end
  end

  // stage 9: row blends
  logic signed [XPW-1:0] rs0, rs1;
  logic signed [RW-1:0]  r0_9_q, r1_9_q;
  logic signed [WW-1:0]  wy9_q;

  assign rs0 = (p0_8_q + HALF_XP) >>> F;
  assign rs1 = (p1_8_q + HALF_XP) >>> F;

  always_ff @(posedge clk_i) begin
    if (ld[9]) begin
      r0_9_q <= RW'(l00_8_q) + RW'(rs0);
      r1_9_q <= RW'(l10_8_q) + RW'(rs1);
      wy9_q  <= wy8_q;
    end
  end

  // stage 10: y difference
  logic signed [YW-1:0] dy10_q;
  logic signed [RW-1:0] r0_10_q;
  logic signed [WW-1:0] wy10_q;

  always_ff @(posedge clk_i) begin
    if (ld[10]) begin
      dy10_q  <= YW'(r1_9_q) - YW'(r0_9_q);
      r0_10_q <= r0_9_q;
      wy10_q  <= wy9_q;
    end
  end

  // stage 11: y weight product
  logic signed [YPW-1:0] py11_q;
  logic signed [RW-1:0]  r0_11_q;

  always_ff @(posedge clk_i) begin
    if (ld[11]) begin
      py11_q  <= YPW'(wy10_q) * YPW'(dy10_q);
      r0_11_q <= r0_10_q;
    end
  end

  // stage 12: column blend
  logic signed [YPW-1:0] rsy;
  logic signed [FW-1:0]  r12_q;

  assign rsy = (py11_q + HALF_YP) >>> F;

  always_ff @(posedge clk_i) begin
    if (ld[12]) begin
      r12_q <= FW'(r0_11_q) + FW'(rsy);
    end
  end

  // stage 13: round to output format and saturate
  logic signed [FW-1:0]      rr;
  logic signed [FW-1:0]      rc;
  logic signed [NOISE_W-1:0] noise13_q;

  assign rr = (r12_q + HALF_F) >>> SH;

  always_comb begin
    rc = rr;
    if (rr > OUT_HI) begin
      rc = OUT_HI;
    end else if (rr < OUT_LO) begin
      rc = OUT_LO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[13]) begin
      noise13_q <= NOISE_W'(rc);
    end
  end

  assign noise_value_o = noise13_q;

endmodule

`default_nettype wire

// File: hw/rtl/vn2d_chk.sv
// Port-level checker for the value noise top level, bound to it below.
`default_nettype none

module vn2d_chk (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic signed [vn2d_pkg::NOISE_W-1:0]  noise_value_o
);
  import vn2d_pkg::*;

  localparam logic [4:0] DEPTH = 5'd13;

  // transactions accepted but not yet delivered
  logic [4:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 5'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled result changed or dropped");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 5'd0)
    else $error("result without a pending transaction");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH)
    else $error("more transactions in flight than stages");

endmodule

bind value_noise_2d_top vn2d_chk u_vn2d_chk (.*);

`default_nettype wire
